// ===== hw/rtl/qmu_pkg.sv =====
// Shared types and constants for the queued mutex unit.
// Used by the interfaces, the waiter queue, the control logic and the top level.
`timescale 1ns / 1ps

package qmu_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_LOCK    = 2'd0;
  localparam logic [1:0] OP_TRYLOCK = 2'd1;
  localparam int         OP_UNLOCK_BIT = 1;

  typedef enum logic [2:0] {
    ST_ACQUIRED  = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_BUSY      = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_HANDOFF   = 3'd4,
    ST_NOT_OWNER = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

  typedef logic [ID_BITS-1:0] tid_t;

  typedef struct packed {
    logic push;
    logic pop;
    tid_t push_id;
  } fifo_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    tid_t head_id;
  } fifo_stat_t;

  typedef struct packed {
    status_t status;
    logic    owner_valid;
    tid_t    owner_id;
    logic    woken_valid;
    tid_t    woken_id;
  } rsp_t;

endpackage

// ===== hw/rtl/qmu_if.sv =====
// Valid/ready channel interfaces for mutex requests and responses.
// Depends on qmu_pkg for the payload widths.
`timescale 1ns / 1ps

interface qmu_req_if;
  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic [qmu_pkg::ID_BITS-1:0] thread_id;

  modport source (output valid, output operation, output thread_id, input ready);
  modport sink   (input valid, input operation, input thread_id, output ready);
endinterface

interface qmu_rsp_if;
  logic                valid;
  logic                ready;
  logic [2:0]          status;
  logic                owner_valid;
  logic [qmu_pkg::ID_BITS-1:0] owner_id;
  logic                woken_valid;
  logic [qmu_pkg::ID_BITS-1:0] woken_id;

  modport source (output valid, output status, output owner_valid, output owner_id,
                  output woken_valid, output woken_id, input ready);
  modport sink   (input valid, input status, input owner_valid, input owner_id,
                  input woken_valid, input woken_id, output ready);
endinterface

// ===== hw/rtl/qmu_fifo.sv =====
// Circular queue of waiting thread ids with head/tail pointers and a fill count.
// Depends on qmu_pkg for depth, widths and the command/status structs.
`timescale 1ns / 1ps

module qmu_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  qmu_pkg::fifo_cmd_t cmd,
  output qmu_pkg::fifo_stat_t stat
);

  localparam logic [qmu_pkg::PTR_W-1:0] LAST_SLOT = qmu_pkg::PTR_W'(qmu_pkg::QUEUE_DEPTH - 1);
  localparam logic [qmu_pkg::CNT_W-1:0] FULL_CNT  = qmu_pkg::CNT_W'(qmu_pkg::QUEUE_DEPTH);

  qmu_pkg::tid_t               slots_r [qmu_pkg::QUEUE_DEPTH];
  logic [qmu_pkg::PTR_W-1:0]   head_r, head_nxt;
  logic [qmu_pkg::PTR_W-1:0]   tail_r, tail_nxt;
  logic [qmu_pkg::CNT_W-1:0]   count_r, count_nxt;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (cmd.pop) begin
      head_nxt  = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
    if (cmd.push) begin
      tail_nxt  = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // entries carry no reset; only written slots are ever read
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      slots_r[tail_r] <= cmd.push_id;
    end
  end

  assign stat.full    = (count_r == FULL_CNT);
  assign stat.empty   = (count_r == '0);
  assign stat.head_id = slots_r[head_r];

endmodule

// ===== hw/rtl/qmu_ctrl.sv =====
// Ownership registers and per-request decision logic of the mutex.
// Depends on qmu_pkg; drives the waiter queue and forms the response word.
`timescale 1ns / 1ps

module qmu_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [1:0]          operation,
  input  qmu_pkg::tid_t       thread_id,
  input  qmu_pkg::fifo_stat_t fifo_stat,
  output qmu_pkg::fifo_cmd_t  fifo_cmd,
  output qmu_pkg::rsp_t       rsp
);

  logic             held_r, held_nxt;
  qmu_pkg::tid_t    holder_r, holder_nxt;
  qmu_pkg::status_t status;
  logic             woke;
  logic             push, pop;

  always_comb begin
    held_nxt   = held_r;
    holder_nxt = holder_r;
    woke       = 1'b0;
    push       = 1'b0;
    pop        = 1'b0;
    priority if (operation[qmu_pkg::OP_UNLOCK_BIT]) begin
      priority if (!held_r || holder_r != thread_id) begin
        status = qmu_pkg::ST_NOT_OWNER;
      end else if (!fifo_stat.empty) begin
        // hand ownership straight to the oldest waiter
        pop        = 1'b1;
        holder_nxt = fifo_stat.head_id;
        woke       = 1'b1;
        status     = qmu_pkg::ST_HANDOFF;
      end else begin
        held_nxt   = 1'b0;
        holder_nxt = '0;
        status     = qmu_pkg::ST_RELEASED;
      end
    end else if (!held_r) begin
      held_nxt   = 1'b1;
      holder_nxt = thread_id;
      status     = qmu_pkg::ST_ACQUIRED;
    end else if (operation == qmu_pkg::OP_TRYLOCK) begin
      status = qmu_pkg::ST_BUSY;
    end else if (fifo_stat.full) begin
      status = qmu_pkg::ST_FULL;
    end else begin
      push   = 1'b1;
      status = qmu_pkg::ST_QUEUED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= 1'b0;
      holder_r <= '0;
    end else if (accept) begin
      held_r   <= held_nxt;
      holder_r <= holder_nxt;
    end
  end

  assign fifo_cmd.push    = accept & push;
  assign fifo_cmd.pop     = accept & pop;
  assign fifo_cmd.push_id = thread_id;

  assign rsp.status      = status;
  assign rsp.owner_valid = held_nxt;
  assign rsp.owner_id    = held_nxt ? holder_nxt : '0;
  assign rsp.woken_valid = woke;
  assign rsp.woken_id    = woke ? fifo_stat.head_id : '0;

endmodule

// ===== hw/rtl/queued_mutex_unit.sv =====
// Queued hardware mutex: request channel in, one response word per request out.
// Uses qmu_pkg, qmu_req_if/qmu_rsp_if, qmu_ctrl and qmu_fifo.
//
// in_req carries a lock, trylock or unlock request with the requesting thread id.
// Codes 2 and 3 both decode as unlock. out_rsp returns, for each request, its
// status, the owner after the request and, on a handoff, the thread that was woken.
// Lock on a held mutex queues the requester (up to QUEUE_DEPTH waiters, then the
// request is dropped with a queue-full status); unlock by the owner passes the
// mutex to the oldest waiter.
// Response: the word is registered and is on out_rsp in the cycle after the request is taken.
// Throughput: one request per cycle; the decision and the queue pointer update
// sit in a single stage between the request handshake and the response register.
// Stall: while a response waits and out_rsp.ready is low, in_req.ready drops and
// the response word holds; intake resumes in the cycle the word is taken.
// Reset (rst_n low, synchronous): mutex free, owner 0, queue empty, no response
// pending. Queue entries are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module queued_mutex_unit (
  input  logic             clk,
  input  logic             rst_n,
  qmu_req_if.sink          in_req,
  qmu_rsp_if.source        out_rsp
);

  logic                accept;
  logic                out_valid_r;
  qmu_pkg::rsp_t       rsp;
  qmu_pkg::rsp_t       rsp_r;
  qmu_pkg::fifo_cmd_t  fifo_cmd;
  qmu_pkg::fifo_stat_t fifo_stat;

  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign accept       = in_req.valid && in_req.ready;

  qmu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .operation (in_req.operation),
    .thread_id (in_req.thread_id),
    .fifo_stat (fifo_stat),
    .fifo_cmd  (fifo_cmd),
    .rsp       (rsp)
  );

  qmu_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (fifo_cmd),
    .stat  (fifo_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      out_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_r <= rsp;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = rsp_r.status;
  assign out_rsp.owner_valid = rsp_r.owner_valid;
  assign out_rsp.owner_id    = rsp_r.owner_id;
  assign out_rsp.woken_valid = rsp_r.woken_valid;
  assign out_rsp.woken_id    = rsp_r.woken_id;

`ifndef ASSERT_OFF
  a_accept_gives_word : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_rsp.valid)
    else $error("accepted request produced no response word");

  a_handoff_woken : assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid |-> ((out_rsp.status == qmu_pkg::ST_HANDOFF) == out_rsp.woken_valid))
    else $error("woken flag disagrees with handoff status");

  a_handoff_owner : assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && out_rsp.woken_valid |->
      out_rsp.owner_valid && out_rsp.owner_id == out_rsp.woken_id)
    else $error("woken thread is not the new owner");

  a_queue_sane : assert property (@(posedge clk) disable iff (!rst_n)
    !(fifo_stat.full && fifo_stat.empty) && !(fifo_cmd.pop && fifo_stat.empty))
    else $error("waiter queue count inconsistent");
`endif

endmodule

// ===== tb/sv/qmu_checker.sv =====
// Response checker for the queued mutex unit: tracks owner and wait queue,
// predicts one response word per accepted request and compares it on out_rsp.
// Depends on qmu_pkg and the qmu_req_if / qmu_rsp_if channel interfaces.
`timescale 1ns / 1ps

module qmu_checker (
  input  logic clk,
  input  logic rst_n,
  qmu_req_if   req_mon,
  qmu_rsp_if   rsp_mon,
  output int   fail_count,
  output int   pending
);

  logic                      held;
  qmu_pkg::tid_t             holder;
  qmu_pkg::tid_t             waiters [qmu_pkg::QUEUE_DEPTH];
  logic [qmu_pkg::PTR_W-1:0] head_ptr;
  logic [qmu_pkg::PTR_W-1:0] tail_ptr;
  logic [qmu_pkg::CNT_W-1:0] waiter_count;

  qmu_pkg::rsp_t grant_queue [$];

  function automatic logic [qmu_pkg::PTR_W-1:0] wrap_next(
    input logic [qmu_pkg::PTR_W-1:0] p
  );
    return (p == qmu_pkg::PTR_W'(qmu_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Apply one request to the shadow mutex and return the word it should produce.
  function automatic qmu_pkg::rsp_t arbitrate_request(input logic [1:0] op,
                                                      input qmu_pkg::tid_t tid);
    qmu_pkg::rsp_t r;
    r.woken_valid = 1'b0;
    r.woken_id    = '0;
    if (op[qmu_pkg::OP_UNLOCK_BIT]) begin
      if (!held || holder != tid) begin
        r.status = qmu_pkg::ST_NOT_OWNER;
      end else if (waiter_count != 0) begin
        r.woken_valid = 1'b1;
        r.woken_id    = waiters[head_ptr];
        holder        = waiters[head_ptr];
        head_ptr      = wrap_next(head_ptr);
        waiter_count  = waiter_count - 1'b1;
        r.status      = qmu_pkg::ST_HANDOFF;
      end else begin
        held     = 1'b0;
        holder   = '0;
        r.status = qmu_pkg::ST_RELEASED;
      end
    end else if (!held) begin
      held     = 1'b1;
      holder   = tid;
      r.status = qmu_pkg::ST_ACQUIRED;
    end else if (op == qmu_pkg::OP_TRYLOCK) begin
      r.status = qmu_pkg::ST_BUSY;
    end else if (waiter_count >= qmu_pkg::CNT_W'(qmu_pkg::QUEUE_DEPTH)) begin
      r.status = qmu_pkg::ST_FULL;
    end else begin
      waiters[tail_ptr] = tid;
      tail_ptr          = wrap_next(tail_ptr);
      waiter_count      = waiter_count + 1'b1;
      r.status          = qmu_pkg::ST_QUEUED;
    end
    r.owner_valid = held;
    r.owner_id    = held ? holder : '0;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input qmu_pkg::rsp_t want,
                               input qmu_pkg::rsp_t got);
    if (fail_count < 10) begin
      $write("[%0t] %s: exp st=%0d ov=%0b own=%02h wv=%0b wk=%02h",
             $realtime, what, want.status, want.owner_valid, want.owner_id,
             want.woken_valid, want.woken_id);
      $display(" | got st=%0d ov=%0b own=%02h wv=%0b wk=%02h",
               got.status, got.owner_valid, got.owner_id, got.woken_valid,
               got.woken_id);
    end
    fail_count = fail_count + 1;
  endtask

  always @(posedge clk) begin : monitor
    qmu_pkg::rsp_t got;
    qmu_pkg::rsp_t want;
    if (!rst_n) begin
      held         = 1'b0;
      holder       = '0;
      head_ptr     = '0;
      tail_ptr     = '0;
      waiter_count = '0;
      grant_queue.delete();
    end else begin
      // Check the outgoing word before taking the new request, whose own word is registered.
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.status      = qmu_pkg::status_t'(rsp_mon.status);
        got.owner_valid = rsp_mon.owner_valid;
        got.owner_id    = rsp_mon.owner_id;
        got.woken_valid = rsp_mon.woken_valid;
        got.woken_id    = rsp_mon.woken_id;
        if (grant_queue.size() == 0) begin
          want = '0;
          note_mismatch("word with no request outstanding", want, got);
        end else begin
          want = grant_queue.pop_front();
          if (got !== want) note_mismatch("response mismatch", want, got);
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        grant_queue.push_back(arbitrate_request(req_mon.operation, req_mon.thread_id));
      end
    end
    pending <= grant_queue.size();
  end

endmodule

// ===== tb/sv/tb_queued_mutex_unit.sv =====
// Top of the queued mutex unit testbench: clock, reset, request stimulus,
// response back-pressure and the verdict. Uses qmu_pkg, the channel interfaces,
// queued_mutex_unit and qmu_checker.
`timescale 1ns / 1ps

module tb_queued_mutex_unit;

  localparam logic [1:0] OP_UNLOCK     = 2'd2;
  localparam logic [1:0] OP_UNLOCK_ALT = 2'd3;  // bit 1 set, still an unlock
  localparam int RANDOM_ITEMS = 1500;
  localparam int LONG_STALL   = 300;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum int { SEG_FILL, SEG_DRAIN, SEG_MIXED } seg_mode_t;
  typedef enum int { RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC } rx_mode_t;

  logic          clk;
  logic          rst_n;
  int            fail_count;
  int            pending;
  int            taken_count = 0;
  int            cycle_count = 0;
  qmu_pkg::tid_t seen_owner  = '0;
  qmu_pkg::tid_t id_pool [8];

  qmu_req_if in_req ();
  qmu_rsp_if out_rsp ();

  queued_mutex_unit u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  qmu_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (in_req),
    .rsp_mon    (out_rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_req.valid && in_req.ready) taken_count <= taken_count + 1;
    // Follow the owner so that most unlocks come from the right thread.
    if (out_rsp.valid && out_rsp.ready && out_rsp.owner_valid) seen_owner <= out_rsp.owner_id;
  end

  task automatic send_word(input logic [1:0] op, input qmu_pkg::tid_t tid);
    in_req.valid     <= 1'b1;
    in_req.operation <= op;
    in_req.thread_id <= tid;
    do @(posedge clk); while (!in_req.ready);
  endtask

  task automatic wait_for_quiet();
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic qmu_pkg::tid_t pick_tid();
    if ($urandom_range(0, 9) < 7) return id_pool[$urandom_range(0, 7)];
    return qmu_pkg::tid_t'($urandom_range(0, 255));
  endfunction

  task automatic send_random_item(input seg_mode_t mode);
    int            r;
    int            lock_cut;
    int            try_cut;
    qmu_pkg::tid_t tid;
    r = $urandom_range(0, 99);
    case (mode)
      SEG_FILL:  begin lock_cut = 65; try_cut = 80; end
      SEG_DRAIN: begin lock_cut = 20; try_cut = 30; end
      default:   begin lock_cut = 40; try_cut = 65; end
    endcase
    if (r < lock_cut) begin
      send_word(qmu_pkg::OP_LOCK, pick_tid());
    end else if (r < try_cut) begin
      send_word(qmu_pkg::OP_TRYLOCK, pick_tid());
    end else begin
      tid = ($urandom_range(0, 9) < 8) ? seen_owner : pick_tid();
      send_word(($urandom_range(0, 99) < 85) ? OP_UNLOCK : OP_UNLOCK_ALT, tid);
    end
  endtask

  initial begin : request_stream
    int        i;
    int        burst_left;
    int        seg_left;
    seg_mode_t seg_mode;
    in_req.valid     = 1'b0;
    in_req.operation = qmu_pkg::OP_LOCK;
    in_req.thread_id = '0;
    rst_n            = 1'b0;
    id_pool[0] = 8'h00;
    id_pool[1] = 8'hFF;
    for (i = 2; i < 8; i++) id_pool[i] = qmu_pkg::tid_t'($urandom_range(0, 255));
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(OP_UNLOCK, 8'h00);              // unlock while free
    send_word(qmu_pkg::OP_LOCK, 8'h00);       // take a free mutex
    send_word(qmu_pkg::OP_TRYLOCK, 8'hFF);    // busy, not queued
    send_word(qmu_pkg::OP_LOCK, 8'hFF);       // queued behind the owner
    send_word(qmu_pkg::OP_LOCK, 8'h00);       // owner locks again: queued too
    send_word(OP_UNLOCK, 8'hAA);              // not the owner
    send_word(OP_UNLOCK_ALT, 8'h00);          // code three: hand off to the oldest waiter
    send_word(OP_UNLOCK, 8'hFF);              // hand back to the first owner's queued entry
    send_word(OP_UNLOCK, 8'h00);              // no waiter left: free
    send_word(qmu_pkg::OP_TRYLOCK, 8'h55);    // trylock on a free mutex
    for (i = 0; i < qmu_pkg::QUEUE_DEPTH; i++) begin
      send_word(qmu_pkg::OP_LOCK, qmu_pkg::tid_t'(i * 17));
    end
    send_word(qmu_pkg::OP_LOCK, 8'h5A);       // queue full: dropped
    wait_for_quiet();

    burst_left = 0;
    seg_left   = 0;
    seg_mode   = SEG_MIXED;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (seg_left == 0) begin
        seg_mode = seg_mode_t'($urandom_range(0, 2));
        seg_left = $urandom_range(20, 60);
      end
      seg_left--;
      if (i == 500 || i == 1100) begin
        wait_for_quiet();
      end else if (burst_left <= 0) begin
        in_req.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 30);
      end
      burst_left--;
      send_random_item(seg_mode);
    end

    wait_for_quiet();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : result_sink
    int       mode_left;
    rx_mode_t rx_mode;
    bit       long_stall_done;
    out_rsp.ready   = 1'b0;
    mode_left       = 0;
    rx_mode         = RX_OPEN;
    long_stall_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!long_stall_done && taken_count >= 400) begin
        // Hold off long enough for the block to back up and drop in_req.ready.
        out_rsp.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        long_stall_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN:   out_rsp.ready <= 1'b1;
          RX_MOSTLY: out_rsp.ready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: out_rsp.ready <= ($urandom_range(0, 3) == 0);
          default:   out_rsp.ready <= ((cycle_count % 5) != 0);
        endcase
      end
    end
  end

endmodule

// ===== files.f =====
hw/rtl/qmu_pkg.sv
hw/rtl/qmu_if.sv
hw/rtl/qmu_fifo.sv
hw/rtl/qmu_ctrl.sv
hw/rtl/queued_mutex_unit.sv
tb/sv/qmu_checker.sv
tb/sv/tb_queued_mutex_unit.sv
